@@ hdl/image_rotate_flip_engine_defines.svh @@
// assertion macros for the image rotate and flip engine checker
`ifndef IMAGE_ROTATE_FLIP_ENGINE_DEFINES_SVH
`define IMAGE_ROTATE_FLIP_ENGINE_DEFINES_SVH

// same-cycle implication on aclk, off during reset
`define RFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off during reset
`define RFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rfe_pkg.sv @@
// shared types and constants of the image rotate and flip engine
`default_nettype none

package rfe_pkg;

    localparam int CHAN_BITS = 16;
    localparam int SIZE_BITS = 9;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [1:0] {
        MODE_ROT_RIGHT = 2'd0,
        MODE_ROT_LEFT  = 2'd1,
        MODE_FLIP_H    = 2'd2,
        MODE_FLIP_V    = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE          = 2'd0,
        REG_FRAME_WIDTH   = 2'd1,
        REG_FRAME_HEIGHT  = 2'd2,
        REG_COLOUR_PIXELS = 2'd3
    } reg_index_t;

    // frame geometry after clamping, kept as size minus one
    typedef struct packed {
        mode_t                mode;
        logic [SIZE_BITS-1:0] wm1;
        logic [SIZE_BITS-1:0] hm1;
        logic                 colour;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/image_rotate_flip_engine.sv @@
// image rotate and flip engine top level
// Loads a frame in raster order (command 0) and returns it rotated right, rotated left,
// flipped horizontally or flipped vertically, one pixel per emit request (command 1).
// One beat is taken every cycle while the result side keeps up: a load writes the pixel
// store in its accept cycle and an emit reads it, the single write port and the single
// registered read port of the store setting that rate. An emitted pixel passes the read
// register of the store, then the output register, where it waits. The store needs no
// clearing pass after reset; only entries already loaded may be emitted.
`default_nettype none

module image_rotate_flip_engine import rfe_pkg::*; #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  wire logic [SIZE_BITS-1:0]      cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_command,
    input  wire logic [CHAN_BITS-1:0]      s_chan_a,
    input  wire logic [CHAN_BITS-1:0]      s_chan_b,
    input  wire logic [CHAN_BITS-1:0]      s_chan_c,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [CHAN_BITS-1:0]           m_out_a,
    output logic [CHAN_BITS-1:0]           m_out_b,
    output logic [CHAN_BITS-1:0]           m_out_c,
    output logic                           m_frame_end
);

    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;
    localparam int DATA_BITS = 3 * SAMPLE_BITS;

    cfg_t                 cfg;
    logic                 restart;
    logic                 in_fire, load_fire, emit_fire;
    logic [ADDR_BITS-1:0] wr_addr, rd_addr;
    logic [DATA_BITS-1:0] wr_data, rd_data;
    logic                 frame_end;
    logic                 out_free, p1_adv;

    logic p1_valid_reg, p1_valid_next;
    logic p1_end_reg, p1_colour_reg;
    logic m_valid_reg, m_valid_next;
    logic [CHAN_BITS-1:0] out_a_reg, out_b_reg, out_c_reg;
    logic out_end_reg;

    rfe_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg),
        .restart      (restart)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign p1_adv    = p1_valid_reg && out_free;
    assign s_ready   = !p1_valid_reg || out_free;
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && !s_command;
    assign emit_fire = in_fire && s_command;

    rfe_addr #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .restart   (restart),
        .load_fire (load_fire),
        .emit_fire (emit_fire),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .frame_end (frame_end)
    );

    // grey pixels store zero in the two color channels
    assign wr_data = cfg.colour
        ? {s_chan_c[SAMPLE_BITS-1:0], s_chan_b[SAMPLE_BITS-1:0], s_chan_a[SAMPLE_BITS-1:0]}
        : {{(2 * SAMPLE_BITS){1'b0}}, s_chan_a[SAMPLE_BITS-1:0]};

    rfe_store #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_fire),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (emit_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (emit_fire) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            p1_end_reg    <= frame_end;
            p1_colour_reg <= cfg.colour;
        end
        if (p1_adv) begin
            out_a_reg   <= CHAN_BITS'(rd_data[SAMPLE_BITS-1:0]);
            out_b_reg   <= p1_colour_reg ? CHAN_BITS'(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS])
                                         : '0;
            out_c_reg   <= p1_colour_reg ? CHAN_BITS'(rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS])
                                         : '0;
            out_end_reg <= p1_end_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_a     = out_a_reg;
    assign m_out_b     = out_b_reg;
    assign m_out_c     = out_c_reg;
    assign m_frame_end = out_end_reg;

endmodule

`default_nettype wire

@@ hdl/rfe_cfg.sv @@
// configuration registers with frame size clamping
`default_nettype none

module rfe_cfg import rfe_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  wire logic [SIZE_BITS-1:0]      cfg_wr_data,
    output cfg_t                           cfg,
    output logic                           restart
);

    localparam int RESET_SIZE = 256;
    localparam logic [SIZE_BITS-1:0] WM1_MAX = SIZE_BITS'(MAX_WIDTH - 1);
    localparam logic [SIZE_BITS-1:0] HM1_MAX = SIZE_BITS'(MAX_HEIGHT - 1);
    localparam logic [SIZE_BITS-1:0] WM1_RST =
        SIZE_BITS'((RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_SIZE - 1);
    localparam logic [SIZE_BITS-1:0] HM1_RST =
        SIZE_BITS'((RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RESET_SIZE - 1);

    cfg_t cfg_reg, cfg_next;
    logic restart_next;
    logic [SIZE_BITS-1:0] wm1_clamped, hm1_clamped;

    always_comb begin
        if (cfg_wr_data == '0) begin
            wm1_clamped = '0;
        end else if (32'(cfg_wr_data) > MAX_WIDTH) begin
            wm1_clamped = WM1_MAX;
        end else begin
            wm1_clamped = cfg_wr_data - SIZE_BITS'(1);
        end
        if (cfg_wr_data == '0) begin
            hm1_clamped = '0;
        end else if (32'(cfg_wr_data) > MAX_HEIGHT) begin
            hm1_clamped = HM1_MAX;
        end else begin
            hm1_clamped = cfg_wr_data - SIZE_BITS'(1);
        end
    end

    always_comb begin
        cfg_next     = cfg_reg;
        restart_next = 1'b0;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_wr_index))
                REG_MODE: begin
                    cfg_next.mode = mode_t'(cfg_wr_data[1:0]);
                    restart_next  = 1'b1;
                end
                REG_FRAME_WIDTH: begin
                    cfg_next.wm1 = wm1_clamped;
                    restart_next = 1'b1;
                end
                REG_FRAME_HEIGHT: begin
                    cfg_next.hm1 = hm1_clamped;
                    restart_next = 1'b1;
                end
                REG_COLOUR_PIXELS: begin
                    cfg_next.colour = cfg_wr_data[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= MODE_ROT_RIGHT;
            cfg_reg.wm1    <= WM1_RST;
            cfg_reg.hm1    <= HM1_RST;
            cfg_reg.colour <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // counters restart at the same edge as a mode or frame size register write
    assign cfg     = cfg_reg;
    assign restart = restart_next;

endmodule

`default_nettype wire

@@ hdl/rfe_addr.sv @@
// load and emit position counters and store address generation
`default_nettype none

module rfe_addr import rfe_pkg::*; #(
    parameter int COL_BITS = 8,
    parameter int ROW_BITS = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  cfg_t                              cfg,
    input  wire logic                         restart,
    input  wire logic                         load_fire,
    input  wire logic                         emit_fire,
    output logic [ROW_BITS+COL_BITS-1:0]      wr_addr,
    output logic [ROW_BITS+COL_BITS-1:0]      rd_addr,
    output logic                              frame_end
);

    localparam int ADDR_BITS = ROW_BITS + COL_BITS;

    logic [SIZE_BITS-1:0] load_row_reg, load_row_next;
    logic [SIZE_BITS-1:0] load_col_reg, load_col_next;
    logic [ADDR_BITS-1:0] load_addr_reg, load_addr_next;
    logic [SIZE_BITS-1:0] emit_row_reg, emit_row_next;
    logic [SIZE_BITS-1:0] emit_col_reg, emit_col_next;
    logic [SIZE_BITS-1:0] out_wm1, out_hm1;
    logic [SIZE_BITS-1:0] src_row, src_col;
    logic [SIZE_BITS-1:0] frame_w;
    logic [2*SIZE_BITS-1:0] src_lin;
    logic                 rotate;

    assign rotate  = (cfg.mode == MODE_ROT_RIGHT) || (cfg.mode == MODE_ROT_LEFT);
    assign out_wm1 = rotate ? cfg.hm1 : cfg.wm1;
    assign out_hm1 = rotate ? cfg.wm1 : cfg.hm1;

    always_comb begin
        unique case (cfg.mode)
            MODE_ROT_RIGHT: begin
                src_row = cfg.hm1 - emit_col_reg;
                src_col = emit_row_reg;
            end
            MODE_ROT_LEFT: begin
                src_row = emit_col_reg;
                src_col = cfg.wm1 - emit_row_reg;
            end
            MODE_FLIP_H: begin
                src_row = emit_row_reg;
                src_col = cfg.wm1 - emit_col_reg;
            end
            MODE_FLIP_V: begin
                src_row = cfg.hm1 - emit_row_reg;
                src_col = emit_col_reg;
            end
            default: begin
                src_row = emit_row_reg;
                src_col = emit_col_reg;
            end
        endcase
    end

    // raster address with the current frame width as row pitch
    assign frame_w   = cfg.wm1 + SIZE_BITS'(1);
    assign src_lin   = {SIZE_BITS'(0), src_row} * {SIZE_BITS'(0), frame_w}
                       + {SIZE_BITS'(0), src_col};
    assign rd_addr   = src_lin[ADDR_BITS-1:0];
    assign wr_addr   = load_addr_reg;
    assign frame_end = (emit_row_reg == out_hm1) && (emit_col_reg == out_wm1);

    always_comb begin
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        load_addr_next = load_addr_reg;
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;
        if (restart) begin
            load_row_next  = '0;
            load_col_next  = '0;
            load_addr_next = '0;
            emit_row_next  = '0;
            emit_col_next  = '0;
        end else begin
            if (load_fire) begin
                load_addr_next = load_addr_reg + ADDR_BITS'(1);
                if (load_col_reg == cfg.wm1) begin
                    load_col_next = '0;
                    if (load_row_reg == cfg.hm1) begin
                        load_row_next  = '0;
                        load_addr_next = '0;
                    end else begin
                        load_row_next = load_row_reg + SIZE_BITS'(1);
                    end
                end else begin
                    load_col_next = load_col_reg + SIZE_BITS'(1);
                end
            end
            if (emit_fire) begin
                if (emit_col_reg == out_wm1) begin
                    emit_col_next = '0;
                    emit_row_next = (emit_row_reg == out_hm1) ? '0
                                                              : emit_row_reg + SIZE_BITS'(1);
                end else begin
                    emit_col_next = emit_col_reg + SIZE_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            load_addr_reg <= '0;
            emit_row_reg  <= '0;
            emit_col_reg  <= '0;
        end else begin
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            load_addr_reg <= load_addr_next;
            emit_row_reg  <= emit_row_next;
            emit_col_reg  <= emit_col_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rfe_store.sv @@
// pixel store, one write port and one registered read port
`default_nettype none

module rfe_store #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/rfe_checker.sv @@
// port-level checker for the image rotate and flip engine and its bind
`default_nettype none

`include "image_rotate_flip_engine_defines.svh"

module rfe_checker import rfe_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 s_command,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [CHAN_BITS-1:0] m_out_a,
    input wire logic [CHAN_BITS-1:0] m_out_b,
    input wire logic [CHAN_BITS-1:0] m_out_c,
    input wire logic                 m_frame_end
);

    // a result held back keeps its value
    `RFE_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_out_a) && $stable(m_out_b) && $stable(m_out_c) && $stable(m_frame_end), "result changed while stalled")

    // a new result follows an earlier emit beat
    `RFE_ASSERT_NOW(a_result_has_request, $rose(m_valid), $past(s_valid && s_ready && s_command, 2), "result without emit request")

    // a load beat never produces a result
    `RFE_ASSERT_NEXT(a_load_silent, s_valid && s_ready && !s_command && !m_valid, ##1 !$rose(m_valid) || $past(s_valid && s_ready && s_command, 2), "load beat produced a result")

    // the input side never stalls while the output side drains
    `RFE_ASSERT_NOW(a_ready_when_drained, m_ready, s_ready, "input stalled with output ready")

endmodule

bind image_rotate_flip_engine rfe_checker u_rfe_checker (.*);

`default_nettype wire
